// File: hdl/entropy_pool_mixer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the entropy pool mixer
// ----------------------------------------------------------------------------
`ifndef ENTROPY_POOL_MIXER_TOP_MACROS_SVH
`define ENTROPY_POOL_MIXER_TOP_MACROS_SVH

// implication checked only outside reset
`define EPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epm assertion failed");

// next-cycle implication, checked in reset too
`define EPM_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("epm assertion failed");

`endif

// File: hdl/epm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_pkg
// Types and constants shared by the entropy pool mixer modules.
// ----------------------------------------------------------------------------
package epm_pkg;

    localparam int unsigned POOL_WORDS_DEF = 128;
    localparam int unsigned NTAPS          = 6;

    // tap 0 doubles as the read port for read items
    localparam int unsigned TAP_OFFSETS [NTAPS] = '{0, 1, 25, 51, 76, 104};

    localparam logic [31:0] TWIST_TAB [8] = '{
        32'h00000000, 32'h3b6e20c8, 32'h76dc4190, 32'h4db26158,
        32'hedb88320, 32'hd6d6a3e8, 32'h9b64c2b0, 32'ha00ae278
    };

    localparam logic [4:0]  ROT_STEP      = 5'd7;
    localparam logic [4:0]  ROT_STEP_WRAP = 5'd14;
    localparam logic [15:0] COUNT_MAX     = 16'hffff;

    localparam int unsigned CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESEED = 2'd1;
    localparam logic [15:0] MIN_RESEED_RST = 16'd128;
    localparam logic [15:0] MAX_RESEED_RST = 16'd1024;

    typedef enum logic [1:0] {
        OP_MIX   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] entropy_word;
        logic        count_as_new;
        logic [6:0]  read_index;
        logic        last_in_call;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pool_word;
        logic [15:0] new_count;
        logic        reseed_allowed;
        logic        reseed_required;
    } t_out_item;

    // item held between the read issue and the pool write
    typedef struct packed {
        t_opcode     op;
        logic [31:0] word;
        logic [15:0] count;
    } t_s1;

endpackage

// File: hdl/entropy_pool_mixer_top.sv
`timescale 1ns / 1ps
// Pipeline: an accepted item is registered in the item stage, then in the output register.
// Throughput: one item per cycle unless the output stalls; each tap reads its own pool copy, and the
// word written on the edge of a read is forwarded to it.
// Reset (i_rst_n low, synchronous): pointer, rotation, count and pipeline valids
// clear, thresholds reload their defaults; the pool reads as zero through a fill count.
// ----------------------------------------------------------------------------
// entropy_pool_mixer_top
// Entropy pool mixer: twisted GFSR stirring of a word pool, reads and counts.
// ----------------------------------------------------------------------------
module entropy_pool_mixer_top #(
    parameter int unsigned POOL_WORDS = epm_pkg::POOL_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  epm_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output epm_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [epm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    localparam int unsigned AW = $clog2(POOL_WORDS);

    logic                 r_s1_valid;
    logic                 r_out_valid;
    epm_pkg::t_out_item   r_out_item;

    logic                 accept;
    logic                 advance;
    logic                 wr_en;
    logic [epm_pkg::NTAPS-1:0][AW-1:0] tap_addr;
    epm_pkg::t_s1         s1;
    logic [AW-1:0]        s1_addr;
    logic [31:0]          s1_word;
    logic                 allowed;
    logic                 required;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign wr_en      = advance && (s1.op == epm_pkg::OP_MIX);
    assign o_cfg_ready = 1'b1;

    epm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_count     (s1.count),
        .o_allowed   (allowed),
        .o_required  (required)
    );

    epm_state #(.POOL_WORDS(POOL_WORDS)) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_tap_addr (tap_addr),
        .o_s1       (s1),
        .o_s1_addr  (s1_addr)
    );

    epm_pool #(.POOL_WORDS(POOL_WORDS)) u_pool (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_tap_addr (tap_addr),
        .i_wr_en    (wr_en),
        .i_wr_addr  (s1_addr),
        .i_s1       (s1),
        .o_word     (s1_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.pool_word       <= s1_word;
            r_out_item.new_count       <= s1.count;
            r_out_item.reseed_allowed  <= allowed;
            r_out_item.reseed_required <= required;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hdl/epm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_cfg
// Reseed threshold registers and the reseed flag compares.
// ----------------------------------------------------------------------------
module epm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [epm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic [15:0]                    i_count,
    output logic                           o_allowed,
    output logic                           o_required
);

    logic [15:0] r_min;
    logic [15:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= epm_pkg::MIN_RESEED_RST;
            r_max <= epm_pkg::MAX_RESEED_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epm_pkg::CFG_MIN_RESEED: r_min <= i_cfg_data;
                epm_pkg::CFG_MAX_RESEED: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_allowed  = (i_count >= r_min);
    assign o_required = (i_count >= r_max);

endmodule

// File: hdl/epm_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_state
// Add pointer, rotation and new-word count; tap addresses and the item stage.
// ----------------------------------------------------------------------------
module epm_state #(
    parameter int unsigned POOL_WORDS = epm_pkg::POOL_WORDS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  epm_pkg::t_in_item                      i_item,
    output logic [epm_pkg::NTAPS-1:0][$clog2(POOL_WORDS)-1:0] o_tap_addr,
    output epm_pkg::t_s1                           o_s1,
    output logic [$clog2(POOL_WORDS)-1:0]          o_s1_addr
);

    localparam int unsigned AW = $clog2(POOL_WORDS);

    logic [AW-1:0]  r_ptr;
    logic [4:0]     r_rot;
    logic [15:0]    r_count;
    epm_pkg::t_s1   r_s1;
    logic [AW-1:0]  r_s1_addr;

    logic [AW-1:0]  n_ptr;
    logic [4:0]     n_rot;
    logic [15:0]    n_count;
    logic [63:0]    rot_dbl;
    logic [31:0]    rot_word;
    logic           is_mix;

    assign is_mix = (i_item.opcode == epm_pkg::OP_MIX);

    always_comb begin
        n_ptr = (r_ptr == '0) ? AW'(POOL_WORDS - 1) : (r_ptr - AW'(1));
        n_rot = r_rot + ((n_ptr != '0) ? epm_pkg::ROT_STEP : epm_pkg::ROT_STEP_WRAP);
        // rotate left through a doubled word
        rot_dbl  = {i_item.entropy_word, i_item.entropy_word} << r_rot;
        rot_word = rot_dbl[63:32];
        case (i_item.opcode)
            epm_pkg::OP_MIX: begin
                n_count = (i_item.count_as_new && (r_count != epm_pkg::COUNT_MAX))
                          ? (r_count + 16'd1) : r_count;
            end
            epm_pkg::OP_CLEAR: n_count = '0;
            default:           n_count = r_count;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < epm_pkg::NTAPS; g++) begin : g_tap
            logic [AW:0] sum;
            logic [AW:0] wrapped;
            always_comb begin
                sum     = {1'b0, n_ptr} + (AW+1)'(epm_pkg::TAP_OFFSETS[g]);
                wrapped = (sum >= (AW+1)'(POOL_WORDS)) ? (sum - (AW+1)'(POOL_WORDS)) : sum;
                if (g == 0 && i_item.opcode == epm_pkg::OP_READ) begin
                    o_tap_addr[g] = AW'(i_item.read_index);
                end else begin
                    o_tap_addr[g] = wrapped[AW-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_rot   <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            if (is_mix) begin
                r_ptr <= n_ptr;
                r_rot <= n_rot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1.op    <= i_item.opcode;
            r_s1.word  <= rot_word;
            r_s1.count <= n_count;
            r_s1_addr  <= n_ptr;
        end
    end

    assign o_s1      = r_s1;
    assign o_s1_addr = r_s1_addr;

endmodule

// File: hdl/epm_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_pool
// Pool storage: one copy per tap, all written together. Combines the taps,
// applies the twist and writes the result back; a read item returns the tap 0 word.
// ----------------------------------------------------------------------------
module epm_pool #(
    parameter int unsigned POOL_WORDS = epm_pkg::POOL_WORDS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [epm_pkg::NTAPS-1:0][$clog2(POOL_WORDS)-1:0] i_tap_addr,
    input  logic                                   i_wr_en,
    input  logic [$clog2(POOL_WORDS)-1:0]          i_wr_addr,
    input  epm_pkg::t_s1                           i_s1,
    output logic [31:0]                            o_word
);

    localparam int unsigned AW = $clog2(POOL_WORDS);

    // words written so far; writes walk down from the top, so entry k holds
    // data once k + fill reaches the pool size
    logic [AW:0]   r_fill;
    logic [31:0]   r_fwd_data;
    logic [31:0]   mix_x;
    logic [31:0]   mix_word;
    logic [epm_pkg::NTAPS-1:0][31:0] tap_word;

    genvar g;
    generate
        for (g = 0; g < epm_pkg::NTAPS; g++) begin : g_bank
            logic [31:0] r_mem [POOL_WORDS];
            logic [31:0] r_rd_data;
            logic        r_ok;
            logic        r_hit;
            logic [AW:0] fill_sum;

            assign fill_sum = {1'b0, i_tap_addr[g]} + r_fill;

            always_ff @(posedge i_clk) begin
                if (i_wr_en) begin
                    r_mem[i_wr_addr] <= mix_word;
                end
                if (i_rd_en) begin
                    r_rd_data <= r_mem[i_tap_addr[g]];
                    r_ok      <= (fill_sum >= (AW+1)'(POOL_WORDS));
                    // read is read-first; catch the word written on the same edge
                    r_hit     <= i_wr_en && (i_wr_addr == i_tap_addr[g]);
                end
            end

            assign tap_word[g] = r_hit ? r_fwd_data : (r_ok ? r_rd_data : 32'd0);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (r_fill != (AW+1)'(POOL_WORDS))) begin
            r_fill <= r_fill + (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_data <= mix_word;
        end
    end

    always_comb begin
        mix_x = i_s1.word;
        for (int k = 0; k < epm_pkg::NTAPS; k++) begin
            mix_x = mix_x ^ tap_word[k];
        end
        mix_word = {3'b000, mix_x[31:3]} ^ epm_pkg::TWIST_TAB[mix_x[2:0]];
        case (i_s1.op)
            epm_pkg::OP_MIX:  o_word = mix_word;
            epm_pkg::OP_READ: o_word = tap_word[0];
            default:          o_word = 32'd0;
        endcase
    end

endmodule

// File: hdl/epm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_checker
// Port-level checks on the entropy pool mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "entropy_pool_mixer_top_macros.svh"

module epm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input epm_pkg::t_out_item o_out_item
);

    // input only backs up behind a full, stalled output
    `EPM_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `EPM_ASSERT_NEXT(a_rst_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)
    `EPM_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, $past(o_out_valid && i_out_stall && i_rst_n), o_out_valid)
    `EPM_ASSERT_IMPLY(a_out_stable, i_clk, i_rst_n, $past(o_out_valid && i_out_stall && i_rst_n), $stable(o_out_item))

endmodule

bind entropy_pool_mixer_top epm_checker u_epm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
